// ===== hw/rtl/stream_pattern_search_defines.svh =====
// Assertion macros for the stream pattern search block.
// Used by the top level; needs clk and arst_n in scope at the point of use.
`ifndef STREAM_PATTERN_SEARCH_DEFINES_SVH
`define STREAM_PATTERN_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define SPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stream_pattern_search assertion failed");
// next-cycle implication, checked outside reset
`define SPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stream_pattern_search assertion failed");
`else
`define SPS_ASSERT_NOW(label, ante, cons)
`define SPS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/sps_pkg.sv =====
// Package for the stream pattern search block: sizes, register indexes,
// shared structs and the pattern byte selector. No dependencies.
package sps_pkg;

	localparam int MaxPattern = 16;
	localparam int WinIdxW    = $clog2(MaxPattern);
	localparam int LenW       = 5;
	localparam int CountW     = 16;
	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

	// configuration register indexes
	localparam int CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] RegPatternLength = 2'd0;
	localparam logic [CfgIdxW-1:0] RegPatternLow    = 2'd1;
	localparam logic [CfgIdxW-1:0] RegPatternHigh   = 2'd2;

	// shift control for the window cells
	typedef struct packed {
		logic shift;
		logic clear;
	} sps_shift_t;

	// compare setting for one window cell
	typedef struct packed {
		logic       in_use;
		logic [7:0] expected;
	} sps_cmp_t;

	// one result item
	typedef struct packed {
		logic              hit;
		logic [CountW-1:0] match_start;
		logic              buffer_done;
		logic              not_found;
	} sps_result_t;

	// pattern byte idx: low register holds bytes 0..7, high register 8..15
	function automatic logic [7:0] pat_byte(input logic [63:0] lo, input logic [63:0] hi,
		input logic [WinIdxW-1:0] idx);
		logic [127:0] both;
		both = {hi, lo};
		return both[idx*8 +: 8];
	endfunction

endpackage

// ===== hw/rtl/sps_cell.sv =====
// One window cell: holds a stream byte, passes it to the next cell on each
// request and compares the incoming byte with its pattern byte. Uses sps_pkg.
module sps_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sps_pkg::sps_shift_t ctl,
	input  sps_pkg::sps_cmp_t  cmp,
	input  logic [7:0]         din,
	output logic [7:0]         dout,
	output logic               match
);
	import sps_pkg::*;

	logic [7:0] byte_q;

	// window byte; cleared at the end of a buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.shift) begin
			byte_q <= ctl.clear ? 8'd0 : din;
		end
	end

	assign dout = byte_q;
	// compare against the byte that enters this cell now
	assign match = !cmp.in_use || (din == cmp.expected);

endmodule

// ===== hw/rtl/sps_out_skid.sv =====
// Output register with a skid stage for the result channel.
// Uses sps_pkg for the result struct.
module sps_out_skid (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  sps_pkg::sps_result_t load_data,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sps_pkg::sps_result_t out_data
);
	import sps_pkg::*;

	logic        main_v_q;
	logic        skid_v_q;
	sps_result_t main_q;
	sps_result_t skid_q;
	logic        main_free;

	assign main_free = !main_v_q || !out_stall;

	// control: main register drains first, skid catches a stalled request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (main_free) begin
			main_v_q <= skid_v_q || load;
			skid_v_q <= 1'b0;
		end else if (load) begin
			skid_v_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_v_q ? skid_q : load_data;
		end
		if (!main_free && load) begin
			skid_q <= load_data;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

endmodule

// ===== hw/rtl/stream_pattern_search.sv =====
// Stream pattern search: first occurrence of a 1..16 byte pattern per buffer.
// Instantiates sps_cell and sps_out_skid; uses sps_pkg and the defines header.
//
// Usage:
//   Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
//   (0 pattern_length, 1 pattern_low, 2 pattern_high); cfg_ready is always
//   high. Write only while no request is in flight.
//   Input: data_byte and last_byte are taken when in_valid is high and
//   in_stall is low. Output: one result per input byte, taken when out_valid
//   is high and out_stall is low.
//   Throughput: one byte per cycle while in_stall is low. A row of 16 byte cells
//   shifts the window and compares in the cycle the byte is taken; the result
//   is registered in the output register, or in the skid register if it stalls.
//   Stall: results queue in an output register plus a skid register; in_stall
//   rises only when both are full, so input keeps flowing for one extra
//   result while the receiver stalls.
//   Reset: pattern_length 1, pattern registers zero, window, offset and found
//   flag cleared, both output stages empty. No clearing pass is needed.
//   At the last byte of a buffer the offset, window and found flag restart.
`include "stream_pattern_search_defines.svh"
module stream_pattern_search (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sps_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [63:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           last_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output logic [sps_pkg::CountW-1:0]     match_start,
	output logic                           buffer_done,
	output logic                           not_found
);
	import sps_pkg::*;

	logic [LenW-1:0]   pattern_length_q;
	logic [63:0]       pattern_low_q;
	logic [63:0]       pattern_high_q;
	logic [CountW-1:0] count_q;
	logic              found_q;

	logic              accept;
	logic [LenW-1:0]   len_eff;
	logic [LenW-1:0]   len_m1;
	sps_shift_t        ctl;
	logic [7:0]        chain [MaxPattern+1];
	logic [MaxPattern-1:0] cell_match;
	logic              window_eq;
	logic              enough;
	logic              new_hit;
	sps_result_t       res;
	sps_result_t       out_res;
	logic              skid_full;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign in_stall  = skid_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= LenW'(1);
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				RegPatternLength: pattern_length_q <= cfg_data[LenW-1:0];
				RegPatternLow:    pattern_low_q    <= cfg_data;
				RegPatternHigh:   pattern_high_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective length: zero reads as one, above the window as the window size
	always_comb begin
		if (pattern_length_q == '0) begin
			len_eff = LenW'(1);
		end else if (pattern_length_q > LenW'(MaxPattern)) begin
			len_eff = LenW'(MaxPattern);
		end else begin
			len_eff = pattern_length_q;
		end
	end
	assign len_m1 = len_eff - LenW'(1);

	assign ctl.shift = accept;
	assign ctl.clear = last_byte;
	assign chain[0]  = data_byte;

	// row of window cells; cell k compares the byte k positions back and holds it for cell k+1
	for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
		sps_cmp_t        cmp;
		logic [LenW-1:0] pidx;

		assign pidx       = len_m1 - LenW'(k);
		assign cmp.in_use = (LenW'(k) < len_eff);
		assign cmp.expected = pat_byte(pattern_low_q, pattern_high_q, pidx[WinIdxW-1:0]);

		sps_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.cmp    (cmp),
			.din    (chain[k]),
			.dout   (chain[k+1]),
			.match  (cell_match[k])
		);
	end

	// whole-window match, only once the buffer holds len bytes
	assign window_eq = &cell_match;
	assign enough    = (count_q >= CountW'(len_m1));
	assign new_hit   = !found_q && enough && window_eq;

	assign res.hit         = new_hit;
	assign res.match_start = new_hit ? (count_q - CountW'(len_m1)) : '0;
	assign res.buffer_done = last_byte;
	assign res.not_found   = last_byte && !found_q && !new_hit;

	// offset counter and found flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			found_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				count_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (count_q != CountMax) begin
					count_q <= count_q + CountW'(1);
				end
				found_q <= found_q || new_hit;
			end
		end
	end

	sps_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.load_data (res),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign hit         = out_res.hit;
	assign match_start = out_res.match_start;
	assign buffer_done = out_res.buffer_done;
	assign not_found   = out_res.not_found;

	// checks
	`SPS_ASSERT_NOW(a_hit_excludes_miss, out_valid && hit, !not_found)
	`SPS_ASSERT_NOW(a_miss_on_last, out_valid && not_found, buffer_done)
	`SPS_ASSERT_NOW(a_skid_behind_main, in_stall, out_valid)
	`SPS_ASSERT_NEXT(a_buffer_restart, accept && last_byte, !found_q && count_q == '0)

endmodule

// ===== tb/stream_pattern_search_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for stream_pattern_search: a directed table, one long buffer
// with the pattern at its end, then random phases with burst traffic.
// Depends on sps_pkg and the stream_pattern_search RTL.
module stream_pattern_search_tb;
	import sps_pkg::*;

	localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
	localparam int RandomBytes   = 1000;
	localparam int HoldCycles    = 300;
	localparam int DrainCycles   = 6;
	localparam int WatchdogLimit = 5000;
	localparam int LongBufBytes  = 200;
	localparam logic [63:0] LongPattern = 64'hEFBE_ADDE;

	typedef enum int {RxOpen, RxLight, RxHeavy, RxPeriodic} rx_mode_e;

	// one row of the directed table: a register write or a byte request
	typedef struct packed {
		logic               is_cfg;
		logic [CfgIdxW-1:0] cfg_idx;
		logic [63:0]        cfg_val;
		logic [7:0]         data;
		logic               last;
		logic               typed;
		sps_result_t        res;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [63:0]       cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        data_byte = '0;
	logic              last_byte = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              hit;
	logic [CountW-1:0] match_start;
	logic              buffer_done;
	logic              not_found;

	// search model state and its copy of the registers
	logic [7:0]        win_bytes [MaxPattern];
	logic [CountW-1:0] buf_offset;
	logic              buf_found;
	logic [LenW-1:0]   pat_len = 5'd1;
	logic [63:0]       pat_lo = '0;
	logic [63:0]       pat_hi = '0;

	sps_result_t predicted_results [$];
	stim_row_t   dir_table [$];

	int  err_cnt = 0;
	int  bytes_sent = 0;
	int  buffers_sent = 0;
	int  cfg_writes = 0;
	int  results_seen = 0;
	int  hits_seen = 0;
	int  misses_seen = 0;
	int  burst_left = 0;
	bit  no_gaps = 1'b0;
	bit  hold_req = 1'b0;
	int  hold_cnt = 0;
	int  rx_cnt = 0;
	rx_mode_e rx_mode = RxOpen;

	stream_pattern_search u_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void clear_search_state();
		foreach (win_bytes[i]) win_bytes[i] = '0;
		buf_offset = '0;
		buf_found = 1'b0;
	endfunction

	// pattern length after clamping to 1..MaxPattern
	function automatic int active_len();
		if (pat_len == 0) return 1;
		if (pat_len > MaxPattern) return MaxPattern;
		return int'(pat_len);
	endfunction

	// advance the search by one byte and return the result it causes
	function automatic sps_result_t search_step(input logic [7:0] b, input logic last);
		sps_result_t  r;
		int           len;
		logic [127:0] pat;
		logic         eq;
		len = active_len();
		pat = {pat_hi, pat_lo};
		r = '0;
		for (int i = MaxPattern - 1; i > 0; i--) win_bytes[i] = win_bytes[i - 1];
		win_bytes[0] = b;
		// oldest window byte lines up with pattern byte 0
		if (!buf_found && buf_offset >= len - 1) begin
			eq = 1'b1;
			for (int i = 0; i < len; i++)
				if (win_bytes[len - 1 - i] != pat[i*8 +: 8]) eq = 1'b0;
			if (eq) begin
				r.hit = 1'b1;
				r.match_start = CountW'(buf_offset - (len - 1));
				buf_found = 1'b1;
			end
		end
		if (buf_offset != CountMax) buf_offset++;
		r.buffer_done = last;
		r.not_found = last && !buf_found;
		if (last) clear_search_state();
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.cfg_idx = idx;
		r.cfg_val = val;
		return r;
	endfunction

	function automatic stim_row_t byte_row(input logic [7:0] d, input logic l, input logic typed,
		input logic h, input logic [CountW-1:0] s, input logic n);
		stim_row_t r;
		r = '0;
		r.data = d;
		r.last = l;
		r.typed = typed;
		r.res = {h, s, l, n};
		return r;
	endfunction

	// pattern word: extremes, fully random, or bytes from a four-symbol alphabet
	function automatic logic [63:0] rand_pattern_word();
		logic [63:0] w;
		logic [1:0]  sym;
		case ($urandom_range(0, 9))
			0: w = '0;
			1: w = '1;
			2, 3: w = {$urandom, $urandom};
			default: begin
				for (int i = 0; i < 8; i++) begin
					sym = 2'($urandom_range(0, 3));
					w[i*8 +: 8] = {4{sym}};
				end
			end
		endcase
		return w;
	endfunction

	// buffer byte biased toward pattern bytes so partial matches are common
	function automatic logic [7:0] fill_byte(input int len);
		logic [127:0] pat;
		logic [1:0]   sym;
		logic [7:0]   b;
		int           idx;
		pat = {pat_hi, pat_lo};
		case ($urandom_range(0, 4))
			0, 1: begin
				idx = $urandom_range(0, len - 1);
				b = pat[idx*8 +: 8];
			end
			2: begin
				sym = 2'($urandom_range(0, 3));
				b = {4{sym}};
			end
			default: b = 8'($urandom);
		endcase
		return b;
	endfunction

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			RegPatternLength: pat_len = val[LenW-1:0];
			RegPatternLow:    pat_lo = val;
			RegPatternHigh:   pat_hi = val;
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// offer one byte request, with a random gap between bursts unless no_gaps is set
	task automatic send_byte(input logic [7:0] d, input logic l, input logic typed,
		input sps_result_t res);
		sps_result_t predicted;
		if (burst_left == 0) begin
			if (!no_gaps)
				repeat ($urandom_range(0, 6)) begin
					@(negedge clk);
					in_valid <= 1'b0;
				end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		do @(posedge clk); while (in_stall);
		predicted = search_step(d, l);
		predicted_results.push_back(typed ? res : predicted);
		bytes_sent++;
		if (l) buffers_sent++;
	endtask

	// stop offering and let every outstanding result come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (predicted_results.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// new settings at random (always in the first phase), then a few buffers; the last one may stay open
	task automatic random_phase(input bit pressure, input bit first);
		logic [LenW-1:0] new_len;
		logic [7:0]      bytes_q [$];
		logic [127:0]    pat;
		int              len, n_bufs, blen, pos;
		bit              noise, end_buf, l;
		wait_drained();
		if (first || $urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 9))
				0: new_len = 5'd0;
				1: new_len = 5'd16;
				2: new_len = LenW'($urandom_range(17, 31));
				3, 4, 5: new_len = LenW'($urandom_range(1, 4));
				default: new_len = LenW'($urandom_range(1, 16));
			endcase
			write_reg(RegPatternLength, {{(64-LenW){1'b0}}, new_len});
		end
		if (first || $urandom_range(0, 1) != 0) write_reg(RegPatternLow, rand_pattern_word());
		if (first || $urandom_range(0, 1) != 0) write_reg(RegPatternHigh, rand_pattern_word());
		if ($urandom_range(0, 7) == 0) write_reg(RegUnused, {$urandom, $urandom});
		len = active_len();
		pat = {pat_hi, pat_lo};
		if (pressure) begin
			no_gaps = 1'b1;
			hold_req = 1'b1;
		end
		n_bufs = pressure ? 5 : $urandom_range(1, 5);
		for (int b = 0; b < n_bufs; b++) begin
			blen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
			noise = ($urandom_range(0, 4) == 0);
			bytes_q = {};
			for (int i = 0; i < blen; i++)
				bytes_q.push_back(noise ? 8'($urandom) : fill_byte(len));
			// plant one or two copies so hits and later matches occur
			if (!noise && blen >= len && $urandom_range(0, 4) != 0)
				repeat ($urandom_range(1, 2)) begin
					pos = $urandom_range(0, blen - len);
					for (int i = 0; i < len; i++) bytes_q[pos + i] = pat[i*8 +: 8];
				end
			end_buf = (b != n_bufs - 1) || ($urandom_range(0, 3) != 0);
			for (int i = 0; i < blen; i++) begin
				l = (end_buf && i == blen - 1) || (noise && $urandom_range(0, 9) == 0);
				send_byte(bytes_q[i], l, 1'b0, '0);
			end
		end
		no_gaps = 1'b0;
	endtask

	// receiver stall: long hold on request, otherwise a mode that rx_cnt re-picks at random
	always @(negedge clk) begin
		if (hold_req) begin
			out_stall <= 1'b1;
			if (hold_cnt == HoldCycles) begin
				hold_req = 1'b0;
				hold_cnt = 0;
			end else begin
				hold_cnt++;
			end
		end else begin
			rx_cnt++;
			if (rx_cnt % 64 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
			case (rx_mode)
				RxOpen:   out_stall <= 1'b0;
				RxLight:  out_stall <= ($urandom_range(0, 9) < 3);
				RxHeavy:  out_stall <= ($urandom_range(0, 9) < 7);
				default:  out_stall <= (rx_cnt % 4 == 0);
			endcase
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_result
		sps_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_results.size() == 0) begin
				$error("result with no request outstanding");
				err_cnt++;
			end else begin
				want = predicted_results.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					err_cnt++;
				end
				if (match_start !== want.match_start) begin
					$error("match_start: expected %0d, got %0d", want.match_start, match_start);
					err_cnt++;
				end
				if (buffer_done !== want.buffer_done) begin
					$error("buffer_done: expected %0d, got %0d", want.buffer_done, buffer_done);
					err_cnt++;
				end
				if (not_found !== want.not_found) begin
					$error("not_found: expected %0d, got %0d", want.not_found, not_found);
					err_cnt++;
				end
				results_seen++;
				if (want.hit) hits_seen++;
				if (want.not_found) misses_seen++;
			end
		end
	end

	// watchdog: too long without any request moving on any channel
	initial begin : watchdog
		int idle_run;
		idle_run = 0;
		while (idle_run < WatchdogLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("watchdog: no request moved for %0d cycles", WatchdogLimit);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		int random_target;
		int phase;
		clear_search_state();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// after reset: one zero byte is the pattern
		dir_table.push_back(byte_row(8'h00, 1'b0, 1'b1, 1'b1, 16'd0, 1'b0));
		dir_table.push_back(byte_row(8'hFF, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0));
		dir_table.push_back(byte_row(8'hFF, 1'b1, 1'b1, 1'b0, 16'd0, 1'b1));
		// zero length acts as one byte
		dir_table.push_back(cfg_row(RegPatternLength, 64'd0));
		dir_table.push_back(cfg_row(RegPatternLow, 64'hFF));
		dir_table.push_back(byte_row(8'hFF, 1'b1, 1'b1, 1'b1, 16'd0, 1'b0));
		// three bytes; a buffer boundary splits the first attempt
		dir_table.push_back(cfg_row(RegPatternLength, 64'd3));
		dir_table.push_back(cfg_row(RegPatternLow, 64'h43_4241));
		dir_table.push_back(byte_row(8'h41, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0));
		dir_table.push_back(byte_row(8'h42, 1'b1, 1'b1, 1'b0, 16'd0, 1'b1));
		dir_table.push_back(byte_row(8'h43, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0));
		dir_table.push_back(byte_row(8'h41, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0));
		dir_table.push_back(byte_row(8'h42, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0));
		dir_table.push_back(byte_row(8'h43, 1'b1, 1'b1, 1'b1, 16'd1, 1'b0));
		// over-range length clamps to sixteen bytes, all ones
		dir_table.push_back(cfg_row(RegPatternLength, 64'd31));
		dir_table.push_back(cfg_row(RegPatternLow, '1));
		dir_table.push_back(cfg_row(RegPatternHigh, '1));
		for (int i = 0; i < MaxPattern; i++)
			dir_table.push_back(byte_row(8'hFF, i == MaxPattern - 1, i == MaxPattern - 1,
				i == MaxPattern - 1, 16'd0, 1'b0));

		foreach (dir_table[i]) begin
			if (dir_table[i].is_cfg) begin
				wait_drained();
				write_reg(dir_table[i].cfg_idx, dir_table[i].cfg_val);
			end else begin
				send_byte(dir_table[i].data, dir_table[i].last, dir_table[i].typed,
					dir_table[i].res);
			end
		end

		// one long buffer, pattern only at its very end
		wait_drained();
		write_reg(RegPatternLength, 64'd4);
		write_reg(RegPatternLow, LongPattern);
		no_gaps = 1'b1;
		for (int i = 0; i < LongBufBytes - 4; i++) send_byte(8'($urandom_range(0, 8'h7F)), 1'b0,
			1'b0, '0);
		for (int i = 0; i < 4; i++) send_byte(LongPattern[i*8 +: 8], i == 3, 1'b0, '0);
		no_gaps = 1'b0;

		// random phases; two of them run against a long receiver hold
		random_target = bytes_sent + RandomBytes;
		phase = 0;
		while (bytes_sent < random_target) begin
			random_phase(phase == 3 || phase == 12, phase == 0);
			phase++;
		end

		wait_drained();
		$display("%0d bytes in %0d buffers over %0d random phases, %0d register writes",
			bytes_sent, buffers_sent, phase, cfg_writes);
		$display("%0d results checked: %0d first matches, %0d buffers with no match",
			results_seen, hits_seen, misses_seen);
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
